@@ sv/vsa_pkg.sv @@
`timescale 1ns / 1ps

package vsa_pkg;

    // Fixed widths of the channel fields.
    localparam int ACTION_W     = 3;
    localparam int SLOT_IN_W    = 6;
    localparam int GEN_PORT_W   = 16;
    localparam int CLIENT_PORT_W = 16;
    localparam int IDX_OUT_W    = 5;
    localparam int COUNT_OUT_W  = 6;

    // Width of the play sequence counter and of each slot's start order.
    localparam int ORDER_W = 64;

    // Command codes carried in the action field.
    localparam logic [ACTION_W-1:0] ACT_PLAY        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_STOP_HANDLE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP_CLIENT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_STOP_ALL    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FINISHED    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_PLAY_WR,
        S_RESULT
    } t_state;

endpackage

@@ sv/voice_slot_allocator.sv @@
`timescale 1ns / 1ps

// Voice slot allocator. The block keeps a pool of NUM_SLOTS voice slots and hands them out
// through handles made of a slot index and a generation. One command beat goes in, one
// result beat comes out. A play with a valid source takes the lowest-numbered idle slot, or,
// when all slots are busy, steals the slot that started longest ago (lowest index on a tie);
// its generation advances and skips zero, and the result carries the new handle. Stop by
// handle frees a slot only when the generation matches; stop by client, stop all and voice
// finished are also supported, and every result reports the number of active slots. The
// per-slot generation, start order and owner live in one synchronous RAM with a registered
// read; the active flags and a written flag per slot are flip-flops, so an entry never
// written reads as zero and no clearing pass is needed after reset. The block works on one
// command at a time. Play and stop by client sweep the RAM one entry per cycle; stop by
// handle reads its slot from the RAM and then checks it, and stop all, voice finished and
// rejected or unused commands go straight to the result. The result sits in an output
// register, so a held result does not delay the sweep of the next command.

module voice_slot_allocator #(
    parameter int NUM_SLOTS   = 32,
    parameter int GEN_BITS    = 16,
    parameter int CLIENT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [vsa_pkg::ACTION_W-1:0]       i_action,
    input  logic                               i_source_valid,
    input  logic [vsa_pkg::SLOT_IN_W-1:0]      i_slot_index,
    input  logic [vsa_pkg::GEN_PORT_W-1:0]     i_handle_generation,
    input  logic [vsa_pkg::CLIENT_PORT_W-1:0]  i_client_id,

    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [vsa_pkg::IDX_OUT_W-1:0]      o_granted_index,
    output logic [vsa_pkg::GEN_PORT_W-1:0]     o_granted_generation,
    output logic [vsa_pkg::COUNT_OUT_W-1:0]    o_active_count
);

    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int ORDER_W    = vsa_pkg::ORDER_W;
    localparam int MEM_W      = GEN_BITS + ORDER_W + CLIENT_BITS;
    localparam int OUT_IDX_W  = vsa_pkg::IDX_OUT_W;
    localparam int OUT_GEN_W  = vsa_pkg::GEN_PORT_W;
    localparam int OUT_CNT_W  = vsa_pkg::COUNT_OUT_W;
    localparam int RANGE_W    = vsa_pkg::SLOT_IN_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // Each RAM word holds {generation, start order, owner} of one slot.
    logic [MEM_W-1:0]       r_mem [NUM_SLOTS];
    logic [MEM_W-1:0]       r_rd_word;
    logic                   r_rd_written;

    vsa_pkg::t_state        r_state;
    vsa_pkg::t_state        n_state;

    // Slot flags in flip-flops.
    logic [NUM_SLOTS-1:0]   r_active;
    logic [NUM_SLOTS-1:0]   r_written;
    logic [CNT_W-1:0]       r_count;
    logic [ORDER_W-1:0]     r_counter;

    // Captured command.
    logic                   r_is_play;
    logic [IDX_W-1:0]       r_idx;
    logic [GEN_BITS-1:0]    r_hgen;
    logic [CLIENT_BITS-1:0] r_client;

    // Sweep: issue stage and compare stage.
    logic                   r_issue;
    logic [IDX_W-1:0]       r_scan_addr;
    logic                   r_cmp_vld;
    logic                   r_cmp_last;
    logic [IDX_W-1:0]       r_cmp_idx;

    // Candidates found during a play sweep.
    logic                   r_found_idle;
    logic [IDX_W-1:0]       r_idle_idx;
    logic [GEN_BITS-1:0]    r_idle_gen;
    logic [IDX_W-1:0]       r_best_idx;
    logic [GEN_BITS-1:0]    r_best_gen;
    logic [ORDER_W-1:0]     r_best_order;

    // Pending result and output register.
    logic [OUT_IDX_W-1:0]   r_res_idx;
    logic [OUT_GEN_W-1:0]   r_res_gen;
    logic                   r_out_valid;
    logic [OUT_IDX_W-1:0]   r_out_idx;
    logic [OUT_GEN_W-1:0]   r_out_gen;
    logic [OUT_CNT_W-1:0]   r_out_count;

    logic                   in_accept;
    logic                   in_range;
    logic [GEN_BITS-1:0]    in_hgen;
    logic [CLIENT_BITS-1:0] in_client;
    logic                   out_free;
    logic [IDX_W-1:0]       rd_addr;
    logic [MEM_W-1:0]       ent;
    logic [GEN_BITS-1:0]    ent_gen;
    logic [ORDER_W-1:0]     ent_order;
    logic [CLIENT_BITS-1:0] ent_owner;
    logic [IDX_W-1:0]       play_idx;
    logic [GEN_BITS-1:0]    play_old_gen;
    logic [GEN_BITS-1:0]    play_gen_inc;
    logic [GEN_BITS-1:0]    play_gen;
    logic [ORDER_W-1:0]     counter_inc;
    logic                   mem_we;
    logic [MEM_W-1:0]       mem_wdata;

    assign in_accept = i_valid && (r_state == vsa_pkg::S_IDLE);
    assign in_range  = {1'b0, i_slot_index} < RANGE_W'(NUM_SLOTS);
    assign in_hgen   = GEN_BITS'(i_handle_generation);
    assign in_client = CLIENT_BITS'(i_client_id);
    assign out_free  = !r_out_valid || !i_stall;

    // The sweep owns the read port; otherwise it reads the slot named by the command.
    assign rd_addr = (r_state == vsa_pkg::S_SCAN) ? r_scan_addr : i_slot_index[IDX_W-1:0];

    // A slot that was never written reads as all zero.
    assign ent       = r_rd_written ? r_rd_word : '0;
    assign ent_gen   = ent[MEM_W-1 -: GEN_BITS];
    assign ent_order = ent[CLIENT_BITS +: ORDER_W];
    assign ent_owner = ent[CLIENT_BITS-1:0];

    // Grant: an idle slot if the sweep found one, else the oldest slot.
    assign play_idx     = r_found_idle ? r_idle_idx : r_best_idx;
    assign play_old_gen = r_found_idle ? r_idle_gen : r_best_gen;
    assign play_gen_inc = play_old_gen + 1'b1;
    assign play_gen     = (play_gen_inc == '0) ? GEN_BITS'(1) : play_gen_inc;
    assign counter_inc  = r_counter + 1'b1;

    assign mem_we    = (r_state == vsa_pkg::S_PLAY_WR);
    assign mem_wdata = {play_gen, counter_inc, r_client};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[play_idx] <= mem_wdata;
        end
        r_rd_word    <= r_mem[rd_addr];
        r_rd_written <= r_written[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vsa_pkg::S_IDLE: begin
                if (in_accept) begin
                    unique case (i_action)
                        vsa_pkg::ACT_PLAY: begin
                            n_state = i_source_valid ? vsa_pkg::S_SCAN : vsa_pkg::S_RESULT;
                        end
                        vsa_pkg::ACT_STOP_HANDLE: begin
                            n_state = (in_hgen != '0 && in_range) ? vsa_pkg::S_CHECK
                                                                 : vsa_pkg::S_RESULT;
                        end
                        vsa_pkg::ACT_STOP_CLIENT: begin
                            n_state = (in_client != '0) ? vsa_pkg::S_SCAN : vsa_pkg::S_RESULT;
                        end
                        default: begin
                            n_state = vsa_pkg::S_RESULT;
                        end
                    endcase
                end
            end
            vsa_pkg::S_SCAN: begin
                if (r_cmp_vld && r_cmp_last) begin
                    n_state = r_is_play ? vsa_pkg::S_PLAY_WR : vsa_pkg::S_RESULT;
                end
            end
            vsa_pkg::S_CHECK: begin
                n_state = vsa_pkg::S_RESULT;
            end
            vsa_pkg::S_PLAY_WR: begin
                n_state = vsa_pkg::S_RESULT;
            end
            vsa_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = vsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_written    <= '0;
            r_count      <= '0;
            r_counter    <= '0;
            r_is_play    <= 1'b0;
            r_idx        <= '0;
            r_hgen       <= '0;
            r_client     <= '0;
            r_issue      <= 1'b0;
            r_scan_addr  <= '0;
            r_cmp_vld    <= 1'b0;
            r_cmp_last   <= 1'b0;
            r_cmp_idx    <= '0;
            r_found_idle <= 1'b0;
            r_idle_idx   <= '0;
            r_idle_gen   <= '0;
            r_best_idx   <= '0;
            r_best_gen   <= '0;
            r_best_order <= '0;
            r_res_idx    <= '0;
            r_res_gen    <= '0;
            r_out_valid  <= 1'b0;
            r_out_idx    <= '0;
            r_out_gen    <= '0;
            r_out_count  <= '0;
        end else begin
            // In the result state the output register is reloaded below instead.
            if (r_out_valid && !i_stall && r_state != vsa_pkg::S_RESULT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                vsa_pkg::S_IDLE: begin
                    if (in_accept) begin
                        // Capture the command and arm a sweep from slot zero.
                        r_is_play    <= (i_action == vsa_pkg::ACT_PLAY);
                        r_idx        <= i_slot_index[IDX_W-1:0];
                        r_hgen       <= in_hgen;
                        r_client     <= in_client;
                        r_res_idx    <= '0;
                        r_res_gen    <= '0;
                        r_issue      <= 1'b1;
                        r_scan_addr  <= '0;
                        r_cmp_vld    <= 1'b0;
                        r_found_idle <= 1'b0;
                        if (i_action == vsa_pkg::ACT_STOP_ALL) begin
                            r_active <= '0;
                            r_count  <= '0;
                        end
                        if (i_action == vsa_pkg::ACT_FINISHED && in_range) begin
                            if (r_active[i_slot_index[IDX_W-1:0]]) begin
                                r_active[i_slot_index[IDX_W-1:0]] <= 1'b0;
                                r_count <= r_count - 1'b1;
                            end
                        end
                    end
                end
                vsa_pkg::S_SCAN: begin
                    if (r_issue) begin
                        r_cmp_vld  <= 1'b1;
                        r_cmp_idx  <= r_scan_addr;
                        r_cmp_last <= (r_scan_addr == LAST_IDX);
                        if (r_scan_addr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_scan_addr <= r_scan_addr + 1'b1;
                        end
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end

                    if (r_cmp_vld) begin
                        if (r_is_play) begin
                            if (!r_found_idle && !r_active[r_cmp_idx]) begin
                                r_found_idle <= 1'b1;
                                r_idle_idx   <= r_cmp_idx;
                                r_idle_gen   <= ent_gen;
                            end
                            // Strictly older wins, so the lower index keeps a tie.
                            if (r_cmp_idx == '0 || ent_order < r_best_order) begin
                                r_best_idx   <= r_cmp_idx;
                                r_best_gen   <= ent_gen;
                                r_best_order <= ent_order;
                            end
                        end else if (r_active[r_cmp_idx] && ent_owner == r_client) begin
                            r_active[r_cmp_idx] <= 1'b0;
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                vsa_pkg::S_CHECK: begin
                    if (r_active[r_idx] && ent_gen == r_hgen) begin
                        r_active[r_idx] <= 1'b0;
                        r_count <= r_count - 1'b1;
                    end
                end
                vsa_pkg::S_PLAY_WR: begin
                    r_written[play_idx] <= 1'b1;
                    r_active[play_idx]  <= 1'b1;
                    r_counter           <= counter_inc;
                    if (r_found_idle) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_res_idx <= OUT_IDX_W'(play_idx);
                    r_res_gen <= OUT_GEN_W'(play_gen);
                end
                vsa_pkg::S_RESULT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_res_idx;
                        r_out_gen   <= r_res_gen;
                        r_out_count <= OUT_CNT_W'(r_count);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stall              = (r_state != vsa_pkg::S_IDLE);
    assign o_valid              = r_out_valid;
    assign o_granted_index      = r_out_idx;
    assign o_granted_generation = r_out_gen;
    assign o_active_count       = r_out_count;

endmodule

@@ sv/vsa_checker.sv @@
`timescale 1ns / 1ps

module vsa_checker #(
    parameter int NUM_SLOTS = 32
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic [vsa_pkg::ACTION_W-1:0]       i_action,
    input logic                               i_source_valid,
    input logic [vsa_pkg::SLOT_IN_W-1:0]      i_slot_index,
    input logic [vsa_pkg::GEN_PORT_W-1:0]     i_handle_generation,
    input logic [vsa_pkg::CLIENT_PORT_W-1:0]  i_client_id,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [vsa_pkg::IDX_OUT_W-1:0]      o_granted_index,
    input logic [vsa_pkg::GEN_PORT_W-1:0]     o_granted_generation,
    input logic [vsa_pkg::COUNT_OUT_W-1:0]    o_active_count
);

    localparam int CMP_W = vsa_pkg::COUNT_OUT_W + 1;

    // The block takes one command at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while a command was in progress");

    // A held result beat keeps its payload.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_granted_index)
            && $stable(o_granted_generation) && $stable(o_active_count)))
        else $error("stalled result changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_active_count} <= CMP_W'(NUM_SLOTS)))
        else $error("active count above pool size");

    // A grant leaves at least the granted slot active.
    a_grant_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted_generation != '0 && NUM_SLOTS < 64) |-> (o_active_count != '0))
        else $error("grant reported with no active slot");

    // Without a grant the index field is zero.
    a_no_grant_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted_generation == '0) |-> (o_granted_index == '0))
        else $error("index reported without a grant");

endmodule

bind voice_slot_allocator vsa_checker #(
    .NUM_SLOTS(NUM_SLOTS)
) u_vsa_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_valid              (i_valid),
    .o_stall              (o_stall),
    .i_action             (i_action),
    .i_source_valid       (i_source_valid),
    .i_slot_index         (i_slot_index),
    .i_handle_generation  (i_handle_generation),
    .i_client_id          (i_client_id),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_granted_index      (o_granted_index),
    .o_granted_generation (o_granted_generation),
    .o_active_count       (o_active_count)
);
